// File: rtl/adts_fd_pkg.sv
// adts_fd_pkg: shared types, result codes and the sampling rate table
// for the adts frame deframer; no dependencies
package adts_fd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_FRAME_END = 2'd1;
    localparam logic [1:0] KIND_BAD_SYNC  = 2'd2;

    // header layout constants
    localparam logic [11:0] SYNC_WORD     = 12'hFFF;
    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
    localparam logic [12:0] HDR_LEN       = 13'd7;
    localparam logic [12:0] HDR_CRC_LEN   = 13'd9;
    localparam logic [2:0]  HDR_LAST_IDX  = 3'd6;
    localparam logic [12:0] MAX_PAYLOAD_RST = 13'd8191;

    // one classified word passed from the front to the back
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [12:0] dropped;
        logic [12:0] frame_len;
        logic [1:0]  profile;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
        logic        no_crc;
    } t_op;

    // sampling frequency index to hz, reserved indices give zero
    function automatic logic [16:0] rate_hz_lookup(input logic [3:0] idx);
        logic [16:0] hz;
        unique case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

endpackage

// File: rtl/adts_fd_front.sv
// adts_fd_front: sync hunt, header capture and payload accounting,
// emits one classified word per result; depends on adts_fd_pkg
module adts_fd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic [12:0]         i_max_payload,
    output logic                o_push,
    output adts_fd_pkg::t_op    o_op
);
    import adts_fd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT_FF,
        PH_HUNT_F,
        PH_HEADER,
        PH_CRC,
        PH_DATA
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [12:0] r_left, n_left;
    logic [12:0] r_fwd, n_fwd;
    logic [12:0] r_drop, n_drop;
    logic [7:0]  r_hdr [0:5];

    logic        w_hdr_we;
    logic [2:0]  w_hdr_idx;
    logic [12:0] w_fl;
    logic [12:0] w_sub;
    logic [12:0] w_pl;
    logic [12:0] w_left_dec;
    logic [12:0] w_drop_inc;
    logic        w_no_crc;
    logic        w_sync_ok;

    // header fields from the stored header bytes
    assign w_fl      = {r_hdr[3][1:0], r_hdr[4], r_hdr[5][7:5]};
    assign w_no_crc  = r_hdr[1][0];
    assign w_sync_ok = ({r_hdr[0], r_hdr[1][7:4]} == SYNC_WORD);
    assign w_sub     = w_no_crc ? HDR_LEN : HDR_CRC_LEN;
    assign w_pl      = (w_fl > w_sub) ? (w_fl - w_sub) : '0;
    assign w_left_dec = (r_left != '0) ? (r_left - 13'd1) : '0;
    assign w_drop_inc = r_drop + 13'd1;

    // phase sequencing and result classification
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_fwd     = r_fwd;
        n_drop    = r_drop;
        w_hdr_we  = 1'b0;
        w_hdr_idx = r_cnt;
        o_push    = 1'b0;
        o_op.kind           = KIND_PAYLOAD;
        o_op.data           = '0;
        o_op.last           = 1'b0;
        o_op.dropped        = '0;
        o_op.frame_len      = w_fl;
        o_op.profile        = r_hdr[2][7:6];
        o_op.rate_index     = r_hdr[2][5:2];
        o_op.channel_config = {r_hdr[2][0], r_hdr[3][7:6]};
        o_op.no_crc         = w_no_crc;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT_FF: begin
                    if (i_byte == SYNC_BYTE) begin
                        w_hdr_we  = 1'b1;
                        w_hdr_idx = 3'd0;
                        n_phase   = PH_HUNT_F;
                    end
                end
                PH_HUNT_F: begin
                    if (i_byte[7:4] == SYNC_NIBBLE) begin
                        w_hdr_we  = 1'b1;
                        w_hdr_idx = 3'd1;
                        n_cnt     = 3'd2;
                        n_phase   = PH_HEADER;
                    end else begin
                        n_phase = PH_HUNT_FF;
                    end
                end
                PH_HEADER: begin
                    if (r_cnt != HDR_LAST_IDX) begin
                        w_hdr_we = 1'b1;
                        n_cnt    = r_cnt + 3'd1;
                    end else if (!w_sync_ok) begin
                        o_push    = 1'b1;
                        o_op.kind = KIND_BAD_SYNC;
                        n_phase   = PH_HUNT_FF;
                        n_cnt     = '0;
                    end else begin
                        n_left = w_pl;
                        n_fwd  = '0;
                        n_drop = '0;
                        n_cnt  = '0;
                        if (!w_no_crc) begin
                            n_phase = PH_CRC;
                        end else if (w_pl == '0) begin
                            o_push    = 1'b1;
                            o_op.kind = KIND_FRAME_END;
                            o_op.last = 1'b1;
                            n_phase   = PH_HEADER;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_CRC: begin
                    if (r_cnt == '0) begin
                        n_cnt = 3'd1;
                    end else if (r_left == '0) begin
                        o_push    = 1'b1;
                        o_op.kind = KIND_FRAME_END;
                        o_op.last = 1'b1;
                        n_phase   = PH_HEADER;
                        n_cnt     = '0;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_left = w_left_dec;
                    if (r_fwd < i_max_payload) begin
                        n_fwd     = r_fwd + 13'd1;
                        o_push    = 1'b1;
                        o_op.kind = KIND_PAYLOAD;
                        o_op.data = i_byte;
                        if (w_left_dec == '0) begin
                            o_op.last    = 1'b1;
                            o_op.dropped = r_drop;
                            n_phase      = PH_HEADER;
                            n_cnt        = '0;
                        end
                    end else begin
                        n_drop = w_drop_inc;
                        if (w_left_dec == '0) begin
                            o_push       = 1'b1;
                            o_op.kind    = KIND_FRAME_END;
                            o_op.last    = 1'b1;
                            o_op.dropped = w_drop_inc;
                            n_phase      = PH_HEADER;
                            n_cnt        = '0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT_FF;
                end
            endcase
        end
    end

    // phase, counters and header byte capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_FF;
            r_cnt   <= '0;
            r_left  <= '0;
            r_fwd   <= '0;
            r_drop  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_fwd   <= n_fwd;
            r_drop  <= n_drop;
        end
        if (w_hdr_we) begin
            r_hdr[w_hdr_idx] <= i_byte;
        end
    end

endmodule

// File: rtl/adts_fd_queue.sv
// adts_fd_queue: small register queue of classified words between the
// front and the back; depends on adts_fd_pkg
module adts_fd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  adts_fd_pkg::t_op    i_op,
    input  logic                i_pop,
    output adts_fd_pkg::t_op    o_op,
    output logic                o_full,
    output logic                o_empty
);
    import adts_fd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_op      = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// File: rtl/adts_fd_back.sv
// adts_fd_back: pops classified words, formats result fields and holds
// them in the output register; depends on adts_fd_pkg
module adts_fd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adts_fd_pkg::t_op    i_op,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_payload_byte,
    output logic                o_frame_last,
    output logic [12:0]         o_frame_len,
    output logic [1:0]          o_profile,
    output logic [3:0]          o_rate_index,
    output logic [16:0]         o_rate_hz,
    output logic [2:0]          o_channel_config,
    output logic                o_no_crc,
    output logic [12:0]         o_dropped_bytes
);
    import adts_fd_pkg::*;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_data;
    logic        r_last;
    logic [12:0] r_frame_len;
    logic [1:0]  r_profile;
    logic [3:0]  r_rate_index;
    logic [16:0] r_rate_hz;
    logic [2:0]  r_channel_config;
    logic        r_no_crc;
    logic [12:0] r_dropped;
    logic        w_bad;

    // load a new word whenever the output register is free or being taken
    assign o_pop = !i_q_empty && (!r_valid || i_ready);
    assign w_bad = (i_op.kind == KIND_BAD_SYNC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        // bad syncword results carry only their kind
        if (o_pop) begin
            r_kind           <= i_op.kind;
            r_data           <= w_bad ? '0 : i_op.data;
            r_last           <= w_bad ? 1'b0 : i_op.last;
            r_frame_len      <= w_bad ? '0 : i_op.frame_len;
            r_profile        <= w_bad ? '0 : i_op.profile;
            r_rate_index     <= w_bad ? '0 : i_op.rate_index;
            r_rate_hz        <= w_bad ? '0 : rate_hz_lookup(i_op.rate_index);
            r_channel_config <= w_bad ? '0 : i_op.channel_config;
            r_no_crc         <= w_bad ? 1'b0 : i_op.no_crc;
            r_dropped        <= w_bad ? '0 : i_op.dropped;
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_data;
    assign o_frame_last     = r_last;
    assign o_frame_len      = r_frame_len;
    assign o_profile        = r_profile;
    assign o_rate_index     = r_rate_index;
    assign o_rate_hz        = r_rate_hz;
    assign o_channel_config = r_channel_config;
    assign o_no_crc         = r_no_crc;
    assign o_dropped_bytes  = r_dropped;

endmodule

// File: rtl/adts_frame_deframer_top.sv
// adts_frame_deframer_top: top level of the adts deframer, holds the
// max_payload register and joins front, queue and back; depends on adts_fd_pkg
//
//   channel  | handshake                 | word
//   ---------+---------------------------+------------------------------------
//   input    | i_valid / o_ready         | i_stream_byte
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_data (max_payload)
//   output   | o_valid / i_ready         | o_kind ... o_dropped_bytes
//
// one stream byte is taken per cycle while o_ready is high; the front
// classifies it and writes the queue at the edge that takes it, and the output
// register loads from the queue whenever it is free or being taken. the front
// phase machine is the only per-byte loop. reset is synchronous and active
// low: hunt restarts, counters clear, max_payload returns to 8191.
// the queue absorbs output stalls; o_ready falls only when it is full.
module adts_frame_deframer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_last,
    output logic [12:0] o_frame_len,
    output logic [1:0]  o_profile,
    output logic [3:0]  o_rate_index,
    output logic [16:0] o_rate_hz,
    output logic [2:0]  o_channel_config,
    output logic        o_no_crc,
    output logic [12:0] o_dropped_bytes
);
    import adts_fd_pkg::*;

    logic [12:0] r_max_payload;
    logic        w_accept;
    logic        w_push;
    logic        w_pop;
    logic        w_q_full;
    logic        w_q_empty;
    t_op         w_front_op;
    t_op         w_q_op;

    // max_payload register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    // input acceptance follows queue space
    assign o_ready  = !w_q_full;
    assign w_accept = i_valid && o_ready;

    adts_fd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_byte        (i_stream_byte),
        .i_max_payload (r_max_payload),
        .o_push        (w_push),
        .o_op          (w_front_op)
    );

    adts_fd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_op    (w_q_op),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    adts_fd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_q_op),
        .i_q_empty        (w_q_empty),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_frame_last     (o_frame_last),
        .o_frame_len      (o_frame_len),
        .o_profile        (o_profile),
        .o_rate_index     (o_rate_index),
        .o_rate_hz        (o_rate_hz),
        .o_channel_config (o_channel_config),
        .o_no_crc         (o_no_crc),
        .o_dropped_bytes  (o_dropped_bytes)
    );

`ifndef SYNTH
    // a bad syncword result carries nothing but its kind
    a_bad_sync_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_BAD_SYNC) |->
        (!o_frame_last && o_payload_byte == '0 && o_frame_len == '0 &&
         o_rate_hz == '0 && o_dropped_bytes == '0))
        else $error("bad syncword result with nonzero fields");

    // drop count only reported on the final result of a frame
    a_drop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_last) |-> (o_dropped_bytes == '0))
        else $error("dropped bytes reported before frame end");

    // a frame end without data always closes the frame
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_FRAME_END) |-> o_frame_last)
        else $error("frame end result without frame_last");

    // a full queue only happens behind a stalled output register
    a_full_behind_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled while output register empty");
`endif

endmodule
